// ----- rtl/dtwcm_pkg.sv -----
package dtwcm_pkg;

   // default sizes
   localparam int MAX_ROWS_DEF  = 256;
   localparam int MAX_COLS_DEF  = 4096;
   localparam int DIST_BITS_DEF = 24;

   // fixed field widths
   localparam int COST_W     = 32;
   localparam int INDEL_W    = 24;
   localparam int ROWCNT_W   = 9;
   localparam int COLCNT_W   = 13;
   localparam int CODE_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_CNT_W  = $clog2(COST_W);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INDEL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENDED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS     = 2'd3;

   // move codes, numbered in tie-break priority order
   localparam logic [CODE_W-1:0] MOVE_COL_SKIP = 3'd0;
   localparam logic [CODE_W-1:0] MOVE_UP       = 3'd1;
   localparam logic [CODE_W-1:0] MOVE_DIAGONAL = 3'd2;
   localparam logic [CODE_W-1:0] MOVE_LEFT     = 3'd3;
   localparam logic [CODE_W-1:0] MOVE_ROW_SKIP = 3'd4;
   localparam int NUM_MOVES = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FETCH,
      ST_SUM,
      ST_PICK,
      ST_DIV,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic fetch;
      logic sum;
      logic pick;
      logic div_step;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic div_last;
      logic out_free;
   } status_type;

   // saturating cost add
   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
   endfunction

   // column bank rotation
   function automatic logic [1:0] bank_prev(input logic [1:0] s);
      logic [1:0] p;
      case (s)
         2'd0:    p = 2'd2;
         2'd1:    p = 2'd0;
         default: p = 2'd1;
      endcase
      return p;
   endfunction

   function automatic logic [1:0] bank_next(input logic [1:0] s);
      logic [1:0] n;
      case (s)
         2'd0:    n = 2'd1;
         2'd1:    n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- rtl/dtwcm_controller.sv -----
module dtwcm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dtwcm_pkg::status_type  status,
   output dtwcm_pkg::cmd_type     cmd
);

   dtwcm_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtwcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dtwcm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = dtwcm_pkg::ST_LOAD;
            end
         end
         dtwcm_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = dtwcm_pkg::ST_FETCH;
         end
         dtwcm_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = dtwcm_pkg::ST_SUM;
         end
         dtwcm_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = dtwcm_pkg::ST_PICK;
         end
         dtwcm_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = status.done ? dtwcm_pkg::ST_DIV : dtwcm_pkg::ST_SEND;
         end
         dtwcm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = dtwcm_pkg::ST_SEND;
            end
         end
         dtwcm_pkg::ST_SEND: begin
            if (status.out_free) begin
               cmd.send = 1'b1;
               state_in = dtwcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtwcm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/dtwcm_datapath.sv -----
module dtwcm_datapath #(
   parameter int MAX_ROWS  = dtwcm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = dtwcm_pkg::MAX_COLS_DEF,
   parameter int DIST_BITS = dtwcm_pkg::DIST_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dtwcm_pkg::cmd_type                  cmd,
   output dtwcm_pkg::status_type               status,
   input  logic [dtwcm_pkg::INDEL_W-1:0]       indel_cost,
   input  logic                                extended_steps,
   input  logic [dtwcm_pkg::ROWCNT_W-1:0]      row_count,
   input  logic [dtwcm_pkg::COLCNT_W-1:0]      col_count,
   input  logic [DIST_BITS-1:0]                req_local_distance,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [dtwcm_pkg::CODE_W-1:0]        rsp_move_code,
   output logic                                rsp_matrix_done,
   output logic [dtwcm_pkg::COST_W-1:0]        rsp_normalized_cost
);

   localparam int CW_  = dtwcm_pkg::COST_W;
   localparam int AW   = $clog2(MAX_ROWS + 1);
   localparam int RPW  = $clog2(MAX_ROWS);
   localparam int CPW  = $clog2(MAX_COLS);
   localparam int RW   = $clog2(MAX_ROWS + 1);
   localparam int CLW  = $clog2(MAX_COLS + 1);
   localparam int DW   = $clog2(MAX_ROWS + MAX_COLS + 1);
   localparam int MW   = CPW + 1 + dtwcm_pkg::INDEL_W;
   localparam int SW   = (MW > CW_ ? MW : CW_) + 1;
   localparam int NM   = dtwcm_pkg::NUM_MOVES;

   // request and position state
   logic [DIST_BITS-1:0] d_ff;
   logic [RPW-1:0]       row_pos_ff, row_pos_in;
   logic [CPW-1:0]       col_pos_ff, col_pos_in;

   // boundary and first-column tracking
   logic [CW_-1:0] origin_ff, indel0_ff, lin_ff;
   logic [CW_-1:0] row0_prev2_ff, row0_prev_ff, row0_cur_ff;
   logic [1:0]     sel_ff, sel_in;
   logic [DIST_BITS-1:0] dprev_row_ff;

   // column stores
   logic [CW_-1:0]       bank_rd_ff [3];
   logic [DIST_BITS-1:0] dprev_mem [0:MAX_ROWS-1];
   logic [DIST_BITS-1:0] dprev_rd_ff;

   // operand and candidate registers
   logic [CW_-1:0] p_r_ff, q_ff, pr1_ff, pr2_ff, left_ff;
   logic [CW_-1:0] phold1_ff, phold2_ff, best_hold_ff;
   logic [CW_-1:0] cand_ff [NM];

   // pending result and divider
   logic [dtwcm_pkg::CODE_W-1:0] res_code_ff;
   logic                         res_done_ff;
   logic [CW_-1:0]               quo_ff;
   logic [DW-1:0]                rem_ff;
   logic [dtwcm_pkg::DIV_CNT_W-1:0] cnt_ff;

   // output register
   logic                         rsp_valid_ff;
   logic [dtwcm_pkg::CODE_W-1:0] rsp_code_ff;
   logic                         rsp_done_ff;
   logic [CW_-1:0]               rsp_norm_ff;

   // derived cell info
   logic           first_cell, col_start, is_c1, is_c2, is_r1;
   logic [AW-1:0]  r_idx;
   logic [CW_-1:0] origin_now;
   logic [MW-1:0]  row0_prod;
   logic [SW-1:0]  row0_sum;
   logic [CW_-1:0] row0_new;
   logic [1:0]     prev_b, two_b, prev_rd;
   logic [RW-1:0]  rows_eff;
   logic [CLW-1:0] cols_eff;
   logic [DW-1:0]  divisor;
   logic           row_last, col_last, done_now;
   logic [CW_-1:0] best;
   logic [dtwcm_pkg::CODE_W-1:0] code;
   logic           have;
   logic [NM-1:0]  ok;
   logic [DIST_BITS:0] half_col_sum, half_row_sum;
   logic [DW:0]    div_shift;
   logic           div_ge;

   assign first_cell = (row_pos_ff == '0) && (col_pos_ff == '0);
   assign col_start  = (row_pos_ff == '0);
   assign is_c1      = (col_pos_ff == '0);
   assign is_c2      = (col_pos_ff == CPW'(1));
   assign is_r1      = (row_pos_ff == '0);
   assign r_idx      = AW'(row_pos_ff) + AW'(1);

   // effective counts, clamped to the supported range
   always_comb begin
      if (row_count == '0) begin
         rows_eff = RW'(1);
      end else if (32'(row_count) > 32'(MAX_ROWS)) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(row_count);
      end
      if (col_count == '0) begin
         cols_eff = CLW'(1);
      end else if (32'(col_count) > 32'(MAX_COLS)) begin
         cols_eff = CLW'(MAX_COLS);
      end else begin
         cols_eff = CLW'(col_count);
      end
   end

   assign divisor  = DW'(rows_eff) + DW'(cols_eff);
   assign row_last = (RW'(row_pos_ff) + RW'(1)) >= rows_eff;
   assign col_last = (CLW'(col_pos_ff) + CLW'(1)) >= cols_eff;
   assign done_now = row_last && col_last;

   // row-zero cost of the new column: origin + c * indel
   assign origin_now = first_cell ?
                       dtwcm_pkg::sat_add(CW_'(d_ff), CW_'(d_ff)) : origin_ff;
   assign row0_prod  = MW'(CPW'(col_pos_ff) + (CPW+1)'(1)) * MW'(indel_cost);
   assign row0_sum   = SW'(origin_now) + SW'(row0_prod);
   assign row0_new   = (row0_sum > SW'({CW_{1'b1}})) ? {CW_{1'b1}} : row0_sum[CW_-1:0];

   // bank roles: one is written as the current column, the others read
   assign sel_in  = (cmd.load && col_start) ? dtwcm_pkg::bank_next(sel_ff) : sel_ff;
   assign prev_rd = dtwcm_pkg::bank_prev(sel_in);
   assign prev_b  = dtwcm_pkg::bank_prev(sel_ff);
   assign two_b   = dtwcm_pkg::bank_prev(prev_b);

   // request capture and column bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         d_ff <= req_local_distance;
      end
      if (cmd.load) begin
         if (first_cell) begin
            origin_ff <= origin_now;
            indel0_ff <= CW_'(indel_cost);
         end
         if (col_start) begin
            row0_prev2_ff <= row0_prev_ff;
            row0_prev_ff  <= first_cell ? origin_now : row0_cur_ff;
            row0_cur_ff   <= row0_new;
            lin_ff        <= origin_now;
         end else begin
            lin_ff <= dtwcm_pkg::sat_add(lin_ff, indel0_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= '0;
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         dprev_row_ff <= '0;
      end else begin
         sel_ff <= sel_in;
         if (cmd.pick) begin
            row_pos_ff   <= row_pos_in;
            col_pos_ff   <= col_pos_in;
            dprev_row_ff <= d_ff;
         end
      end
   end

   // position advance
   always_comb begin
      if (done_now) begin
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (row_last) begin
         row_pos_in = '0;
         col_pos_in = col_pos_ff + CPW'(1);
      end else begin
         row_pos_in = row_pos_ff + RPW'(1);
         col_pos_in = col_pos_ff;
      end
   end

   // three rotating column banks
   for (genvar b = 0; b < 3; b++) begin : g_bank
      logic [CW_-1:0] mem [0:MAX_ROWS];
      logic [AW-1:0]  rd_addr;
      assign rd_addr = (prev_rd == 2'(b)) ? r_idx : AW'(row_pos_ff);
      always_ff @(posedge clock) begin
         if (cmd.pick && (sel_ff == 2'(b))) begin
            mem[r_idx] <= best;
         end
         if (cmd.load) begin
            bank_rd_ff[b] <= mem[rd_addr];
         end
      end
   end

   // previous-column distances
   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         dprev_mem[row_pos_ff] <= d_ff;
      end
      if (cmd.load) begin
         dprev_rd_ff <= dprev_mem[row_pos_ff];
      end
   end

   // operand gathering
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         p_r_ff  <= is_c1 ? dtwcm_pkg::sat_add(lin_ff, indel0_ff) : bank_rd_ff[prev_b];
         q_ff    <= is_c2 ? lin_ff : (is_r1 ? row0_prev2_ff : bank_rd_ff[two_b]);
         pr1_ff  <= is_r1 ? row0_prev_ff : phold1_ff;
         pr2_ff  <= phold2_ff;
         left_ff <= is_r1 ? row0_cur_ff : best_hold_ff;
      end
   end

   // candidate sums
   assign half_col_sum = (DIST_BITS+1)'(dprev_rd_ff) + (DIST_BITS+1)'(d_ff);
   assign half_row_sum = (DIST_BITS+1)'(dprev_row_ff) + (DIST_BITS+1)'(d_ff);

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         cand_ff[0] <= dtwcm_pkg::sat_add(q_ff, CW_'(half_col_sum[DIST_BITS:1]));
         cand_ff[1] <= dtwcm_pkg::sat_add(p_r_ff, CW_'(indel_cost));
         cand_ff[2] <= dtwcm_pkg::sat_add(pr1_ff, CW_'(d_ff));
         cand_ff[3] <= dtwcm_pkg::sat_add(left_ff, CW_'(indel_cost));
         cand_ff[4] <= dtwcm_pkg::sat_add(pr2_ff, CW_'(half_row_sum[DIST_BITS:1]));
      end
   end

   // cheapest allowed move, lowest code on ties
   assign ok[0] = extended_steps && !is_c1;
   assign ok[1] = 1'b1;
   assign ok[2] = 1'b1;
   assign ok[3] = 1'b1;
   assign ok[4] = extended_steps && !is_r1;

   always_comb begin
      best = '0;
      code = dtwcm_pkg::MOVE_COL_SKIP;
      have = 1'b0;
      // candidate index equals its move code
      for (int k = 0; k < NM; k++) begin
         if (ok[k] && (!have || (cand_ff[k] < best))) begin
            best = cand_ff[k];
            code = dtwcm_pkg::CODE_W'(k);
            have = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         phold2_ff    <= pr1_ff;
         phold1_ff    <= p_r_ff;
         best_hold_ff <= best;
         res_code_ff  <= code;
         res_done_ff  <= done_now;
         quo_ff       <= best;
         rem_ff       <= '0;
         cnt_ff       <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[CW_-2:0], div_ge};
         rem_ff <= div_ge ? DW'(div_shift - (DW+1)'(divisor)) : div_shift[DW-1:0];
         cnt_ff <= cnt_ff + dtwcm_pkg::DIV_CNT_W'(1);
      end
   end

   // restoring divider, one quotient bit per cycle
   assign div_shift = {rem_ff, quo_ff[CW_-1]};
   assign div_ge    = div_shift >= (DW+1)'(divisor);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         rsp_code_ff <= res_code_ff;
         rsp_done_ff <= res_done_ff;
         rsp_norm_ff <= res_done_ff ? quo_ff : '0;
      end
   end

   assign status.done     = done_now;
   assign status.div_last = (cnt_ff == {dtwcm_pkg::DIV_CNT_W{1'b1}});
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_move_code       = rsp_code_ff;
   assign rsp_matrix_done     = rsp_done_ff;
   assign rsp_normalized_cost = rsp_norm_ff;

endmodule

// ----- rtl/dtw_cost_matrix_fill.sv -----
// result: a cell result is loaded into the output register after the load, fetch, sum and
// pick steps, once that register is free; the final cell of a matrix first runs a bit-serial
// normalizing divide; requests: one is taken only once the previous cell has been sent, as
// the controller steps load, fetch, sum and pick around the single-port column bank reads
// reset: synchronous, clears registers to indel 0, plain steps, one row, one column, and
// restarts at the first cell; column stores hold no reset value and are written before use
module dtw_cost_matrix_fill #(
   parameter int MAX_ROWS  = dtwcm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = dtwcm_pkg::MAX_COLS_DEF,
   parameter int DIST_BITS = dtwcm_pkg::DIST_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [DIST_BITS-1:0]                 req_local_distance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dtwcm_pkg::CODE_W-1:0]         rsp_move_code,
   output logic                                 rsp_matrix_done,
   output logic [dtwcm_pkg::COST_W-1:0]         rsp_normalized_cost,
   input  logic                                 csr_write_enable,
   input  logic [dtwcm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dtwcm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   logic [dtwcm_pkg::INDEL_W-1:0]  indel_ff;
   logic                           extended_ff;
   logic [dtwcm_pkg::ROWCNT_W-1:0] rows_ff;
   logic [dtwcm_pkg::COLCNT_W-1:0] cols_ff;

   dtwcm_pkg::cmd_type    cmd;
   dtwcm_pkg::status_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         indel_ff    <= '0;
         extended_ff <= 1'b0;
         rows_ff     <= dtwcm_pkg::ROWCNT_W'(1);
         cols_ff     <= dtwcm_pkg::COLCNT_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dtwcm_pkg::CSR_INDEL:    indel_ff    <= csr_write_data[dtwcm_pkg::INDEL_W-1:0];
            dtwcm_pkg::CSR_EXTENDED: extended_ff <= csr_write_data[0];
            dtwcm_pkg::CSR_ROWS:     rows_ff     <= csr_write_data[dtwcm_pkg::ROWCNT_W-1:0];
            dtwcm_pkg::CSR_COLS:     cols_ff     <= csr_write_data[dtwcm_pkg::COLCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   dtwcm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dtwcm_datapath #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .DIST_BITS (DIST_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .indel_cost          (indel_ff),
      .extended_steps      (extended_ff),
      .row_count           (rows_ff),
      .col_count           (cols_ff),
      .req_local_distance  (req_local_distance),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_move_code       (rsp_move_code),
      .rsp_matrix_done     (rsp_matrix_done),
      .rsp_normalized_cost (rsp_normalized_cost)
   );

endmodule
